### design/tlssni_pkg.sv
// ----------------------------------------------------------------------------
// tlssni_pkg
// Shared types and constants for the TLS ClientHello host-name extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package tlssni_pkg;

   // Parse phases, in packet order
   typedef enum logic [4:0] {
      PH_HDR      = 5'd0,
      PH_SID_LEN  = 5'd1,
      PH_SID_SKIP = 5'd2,
      PH_CS_HI    = 5'd3,
      PH_CS_LO    = 5'd4,
      PH_CS_SKIP  = 5'd5,
      PH_CM_LEN   = 5'd6,
      PH_CM_SKIP  = 5'd7,
      PH_EXT_HI   = 5'd8,
      PH_EXT_LO   = 5'd9,
      PH_ET_HI    = 5'd10,
      PH_ET_LO    = 5'd11,
      PH_EL_HI    = 5'd12,
      PH_EL_LO    = 5'd13,
      PH_EXT_SKIP = 5'd14,
      PH_SNI_L1   = 5'd15,
      PH_SNI_L2   = 5'd16,
      PH_SNI_TYPE = 5'd17,
      PH_SNI_N1   = 5'd18,
      PH_SNI_N2   = 5'd19,
      PH_NAME     = 5'd20,
      PH_DONE     = 5'd21
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND   = 2'd0,
      ST_NOT_CH  = 2'd1,
      ST_BAD     = 2'd2,
      ST_NO_NAME = 2'd3
   } status_type;

   localparam logic [7:0] REC_HANDSHAKE  = 8'h16;
   localparam logic [7:0] VER_MAJOR      = 8'h03;
   localparam logic [7:0] VER_MINOR_LO   = 8'h01;
   localparam logic [7:0] VER_MINOR_HI   = 8'h04;
   localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
   localparam logic [7:0] SNI_HOST_NAME  = 8'h00;
   localparam int         MIN_PACKET     = 43;
   localparam int         HDR_LAST       = 42;
   localparam logic [15:0] SNI_MIN_LEN   = 16'd5;
   localparam logic [15:0] EXT_HEAD_LEN  = 16'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       final_res;
      logic [7:0] name_byte;
      status_type status;
      logic [15:0] name_length;
   } rsp_item_type;

   // Up to two result transactions per accepted byte
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

`default_nettype wire

### design/tls_client_hello_sni_extractor_top.sv
// ----------------------------------------------------------------------------
// tls_client_hello_sni_extractor_top
// Streams a TLS record byte by byte and pulls out the ClientHello host name.
// ----------------------------------------------------------------------------
// Feed one packet byte per req transaction, starting at the TLS record header,
// with req_tlast on the final byte. The record header is checked (handshake
// content type, version 3.1 to 3.4, ClientHello, at least 43 bytes), the
// fixed fields are skipped and the extensions are walked. Bytes of the host
// name from the first server-name extension come out as rsp transactions with
// rsp_tlast low as soon as they arrive. The last packet byte always yields one
// verdict transaction (rsp_tlast high) with the status and, when the status is
// found, the declared name length; a final byte that is also a name byte gives
// two transactions, name byte first. On any status other than found, name
// bytes already delivered for that packet are to be dropped by the consumer.
// Rate: one byte per clock while req_tready is high. Results are registered in
// the output queue before the rsp side; the parse state updates once per byte
// accepted. Results go into a four-entry queue and req_tready drops only while
// fewer than two queue entries are free, so input stalls only follow output
// back-pressure. Packet positions saturate at 2^POSITION_BITS - 1.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_client_hello_sni_extractor_top import tlssni_pkg::*; #(
   parameter int POSITION_BITS = 18
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_packet
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] name_byte, [9:8] status,
                                         // [25:10] name_length, [31:26] zero
   output logic             rsp_tlast    // final_res: verdict transaction
);

   logic         accept;
   push_type     push;
   rsp_item_type out_item;

   assign accept = req_tvalid && req_tready;

   // parse state, one byte per accepted transaction
   tlssni_parser #(
      .POSITION_BITS(POSITION_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .end_of_packet (req_tlast),
      .push          (push)
   );

   // result queue, decouples the two sides
   tlssni_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {6'd0, out_item.name_length, out_item.status, out_item.name_byte};
   assign rsp_tlast = out_item.final_res;

   // a packet end always leaves a verdict to deliver
   a_verdict_queued: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("no result pending after packet end");

   // a verdict carries no name byte
   a_verdict_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("verdict carries a name byte");

   // a name byte carries no status or length
   a_name_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[31:8] == 24'd0))
      else $error("name byte carries status or length");

   // only a found verdict reports a length
   a_len_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast && rsp_tdata[9:8] != ST_FOUND) |->
         (rsp_tdata[25:10] == 16'd0))
      else $error("length on a verdict other than found");

endmodule

`default_nettype wire

### design/tlssni_parser.sv
// ----------------------------------------------------------------------------
// tlssni_parser
// Per-byte ClientHello parse state and result generation.
// ----------------------------------------------------------------------------
`default_nettype none

module tlssni_parser import tlssni_pkg::*; #(
   parameter int POSITION_BITS = 18
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       end_of_packet,
   output push_type        push
);

   typedef logic [POSITION_BITS-1:0] pos_type;

   function automatic pos_type sat_add(pos_type a, logic [15:0] b);
      logic [POSITION_BITS:0] s;
      s = {1'b0, a} + {{(POSITION_BITS-15){1'b0}}, b};
      return s[POSITION_BITS] ? '1 : s[POSITION_BITS-1:0];
   endfunction

   phase_type   phase_ff, phase_in;
   pos_type     pos_ff, pos_in;
   logic [15:0] remain_ff, remain_in;
   logic [7:0]  hold_ff, hold_in;
   pos_type     ext_end_ff, ext_end_in;
   logic        ext_sni_ff, ext_sni_in;
   pos_type     ext_stop_ff, ext_stop_in;
   logic [15:0] name_len_ff, name_len_in;
   status_type  pend_ff, pend_in;
   logic        complete_ff, complete_in;

   logic [15:0] v16;
   pos_type     nxt, sum16, head4, ext_end_eff;
   logic        skip_last;
   logic [15:0] remain_dec;
   status_type  verdict;
   rsp_item_type name_item, verdict_item;

   always_comb begin
      v16         = {hold_ff, data_byte};
      nxt         = sat_add(pos_ff, 16'd1);
      sum16       = sat_add(nxt, v16);
      head4       = sat_add(nxt, EXT_HEAD_LEN);
      ext_end_eff = (phase_ff == PH_EXT_LO) ? sum16 : ext_end_ff;
      skip_last   = (remain_ff <= 16'd1);
      remain_dec  = skip_last ? 16'd0 : remain_ff - 16'd1;

      phase_in    = phase_ff;
      pos_in      = pos_ff;
      remain_in   = remain_ff;
      hold_in     = hold_ff;
      ext_end_in  = ext_end_ff;
      ext_sni_in  = ext_sni_ff;
      ext_stop_in = ext_stop_ff;
      name_len_in = name_len_ff;
      pend_in     = pend_ff;
      complete_in = complete_ff;

      name_item    = '{final_res: 1'b0, name_byte: data_byte,
                       status: ST_FOUND, name_length: 16'd0};
      verdict_item = '{final_res: 1'b1, name_byte: 8'd0,
                       status: ST_FOUND, name_length: 16'd0};
      verdict      = ST_FOUND;
      push         = '0;

      if (accept) begin
         pos_in = nxt;
         unique case (phase_ff)
            PH_HDR: begin
               if ((pos_ff == pos_type'(0) && data_byte != REC_HANDSHAKE) ||
                   (pos_ff == pos_type'(1) && data_byte != VER_MAJOR) ||
                   (pos_ff == pos_type'(2) && (data_byte < VER_MINOR_LO ||
                                               data_byte > VER_MINOR_HI)) ||
                   (pos_ff == pos_type'(5) && data_byte != HS_CLIENT_HELLO)) begin
                  pend_in  = ST_NOT_CH;
                  phase_in = PH_DONE;
               end else if (pos_ff >= pos_type'(HDR_LAST)) begin
                  phase_in = PH_SID_LEN;
               end
            end
            PH_SID_LEN: begin
               remain_in = {8'd0, data_byte};
               phase_in  = (data_byte != 8'd0) ? PH_SID_SKIP : PH_CS_HI;
            end
            PH_SID_SKIP: begin
               remain_in = remain_dec;
               if (skip_last) phase_in = PH_CS_HI;
            end
            PH_CS_HI: begin
               hold_in  = data_byte;
               phase_in = PH_CS_LO;
            end
            PH_CS_LO: begin
               remain_in = v16;
               phase_in  = (v16 != 16'd0) ? PH_CS_SKIP : PH_CM_LEN;
            end
            PH_CS_SKIP: begin
               remain_in = remain_dec;
               if (skip_last) phase_in = PH_CM_LEN;
            end
            PH_CM_LEN: begin
               remain_in = {8'd0, data_byte};
               phase_in  = (data_byte != 8'd0) ? PH_CM_SKIP : PH_EXT_HI;
            end
            PH_CM_SKIP: begin
               remain_in = remain_dec;
               if (skip_last) phase_in = PH_EXT_HI;
            end
            PH_EXT_HI: begin
               hold_in  = data_byte;
               phase_in = PH_EXT_LO;
            end
            PH_EXT_LO: begin
               ext_end_in = sum16;
               if (head4 > ext_end_eff) begin
                  pend_in  = ST_NO_NAME;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_ET_HI;
               end
            end
            PH_ET_HI: begin
               hold_in  = data_byte;
               phase_in = PH_ET_LO;
            end
            PH_ET_LO: begin
               ext_sni_in = (v16 == 16'd0);
               phase_in   = PH_EL_HI;
            end
            PH_EL_HI: begin
               hold_in  = data_byte;
               phase_in = PH_EL_LO;
            end
            PH_EL_LO: begin
               ext_stop_in = sum16;
               if (sum16 > ext_end_ff) begin
                  pend_in  = ST_BAD;
                  phase_in = PH_DONE;
               end else if (ext_sni_ff) begin
                  if (v16 < SNI_MIN_LEN) begin
                     pend_in  = ST_BAD;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_SNI_L1;
                  end
               end else if (v16 == 16'd0) begin
                  if (head4 > ext_end_eff) begin
                     pend_in  = ST_NO_NAME;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_ET_HI;
                  end
               end else begin
                  remain_in = v16;
                  phase_in  = PH_EXT_SKIP;
               end
            end
            PH_EXT_SKIP: begin
               remain_in = remain_dec;
               if (skip_last) begin
                  if (head4 > ext_end_eff) begin
                     pend_in  = ST_NO_NAME;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_ET_HI;
                  end
               end
            end
            PH_SNI_L1: phase_in = PH_SNI_L2;
            PH_SNI_L2: phase_in = PH_SNI_TYPE;
            PH_SNI_TYPE: begin
               if (data_byte != SNI_HOST_NAME) begin
                  pend_in  = ST_BAD;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_SNI_N1;
               end
            end
            PH_SNI_N1: begin
               hold_in  = data_byte;
               phase_in = PH_SNI_N2;
            end
            PH_SNI_N2: begin
               if (sum16 > ext_stop_ff) begin
                  pend_in  = ST_BAD;
                  phase_in = PH_DONE;
               end else begin
                  name_len_in = v16;
                  if (v16 == 16'd0) begin
                     complete_in = 1'b1;
                     pend_in     = ST_FOUND;
                     phase_in    = PH_DONE;
                  end else begin
                     remain_in = v16;
                     phase_in  = PH_NAME;
                  end
               end
            end
            PH_NAME: begin
               push.count = 2'd1;
               push.first = name_item;
               remain_in  = remain_dec;
               if (skip_last) begin
                  complete_in = 1'b1;
                  pend_in     = ST_FOUND;
                  phase_in    = PH_DONE;
               end
            end
            PH_DONE: ;
            default: ;
         endcase

         // verdict from the state as it stands after this byte
         if (nxt < pos_type'(MIN_PACKET) ||
             (phase_in == PH_DONE && pend_in == ST_NOT_CH))
            verdict = ST_NOT_CH;
         else if (phase_in != PH_DONE || nxt < ext_end_in)
            verdict = ST_BAD;
         else if (pend_in == ST_FOUND)
            verdict = complete_in ? ST_FOUND : ST_BAD;
         else
            verdict = pend_in;

         verdict_item.status      = verdict;
         verdict_item.name_length = (verdict == ST_FOUND) ? name_len_in : 16'd0;

         if (end_of_packet) begin
            if (push.count == 2'd1) begin
               push.count  = 2'd2;
               push.second = verdict_item;
            end else begin
               push.count = 2'd1;
               push.first = verdict_item;
            end
            phase_in    = PH_HDR;
            pos_in      = '0;
            remain_in   = 16'd0;
            hold_in     = 8'd0;
            ext_end_in  = '0;
            ext_sni_in  = 1'b0;
            ext_stop_in = '0;
            name_len_in = 16'd0;
            pend_in     = ST_NO_NAME;
            complete_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR;
         pos_ff      <= '0;
         remain_ff   <= 16'd0;
         hold_ff     <= 8'd0;
         ext_end_ff  <= '0;
         ext_sni_ff  <= 1'b0;
         ext_stop_ff <= '0;
         name_len_ff <= 16'd0;
         pend_ff     <= ST_NO_NAME;
         complete_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         remain_ff   <= remain_in;
         hold_ff     <= hold_in;
         ext_end_ff  <= ext_end_in;
         ext_sni_ff  <= ext_sni_in;
         ext_stop_ff <= ext_stop_in;
         name_len_ff <= name_len_in;
         pend_ff     <= pend_in;
         complete_ff <= complete_in;
      end
   end

endmodule

`default_nettype wire

### design/tlssni_out_queue.sv
// ----------------------------------------------------------------------------
// tlssni_out_queue
// Small result queue: takes up to two transactions a cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module tlssni_out_queue import tlssni_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire push_type push,
   output logic        space_ok,
   output logic        out_valid,
   input  wire logic   out_ready,
   output rsp_item_type out_item
);

   rsp_item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  pop;

   always_comb begin
      out_valid = (count_ff != '0);
      out_item  = mem_ff[rd_ptr_ff];
      // room for a name byte and a verdict together
      space_ok  = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
      pop       = out_valid && out_ready;
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
      count_in  = count_ff + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) mem_ff[wr_ptr_ff + QPTR_BITS'(1)] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### tb/sv/tlssni_stream_checker.sv
// ----------------------------------------------------------------------------
// tlssni_stream_checker
// Watches both streams of the host-name extractor, predicts every result
// transaction from the accepted packet bytes and compares them in order.
// ----------------------------------------------------------------------------
module tlssni_stream_checker import tlssni_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          expected_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                 POS_BITS        = 18;
   localparam logic [POS_BITS-1:0] POS_CEILING    = '1;
   localparam logic [15:0]        EXT_SERVER_NAME = 16'h0000;
   localparam int                 PRINT_LIMIT     = 100;

   // parser copy
   phase_type          walk_phase;
   logic [POS_BITS-1:0] byte_pos;
   logic [POS_BITS-1:0] left_in_field;
   logic [POS_BITS-1:0] ext_block_end;
   logic [POS_BITS-1:0] ext_end_here;
   logic [7:0]         held_byte;
   logic [15:0]        ext_kind;
   logic [15:0]        host_len;
   status_type         held_status;
   logic               host_done;

   rsp_item_type       expected_q[$];
   int                 faults = 0;

   function automatic logic [POS_BITS-1:0] pos_add(input logic [POS_BITS-1:0] a,
                                                   input logic [16:0] b);
      logic [POS_BITS:0] sum;
      sum = a + b;
      return (sum > POS_CEILING) ? POS_CEILING : sum[POS_BITS-1:0];
   endfunction

   task automatic clear_walk();
      walk_phase    = PH_HDR;
      byte_pos      = '0;
      left_in_field = '0;
      held_byte     = '0;
      ext_block_end = '0;
      ext_kind      = '0;
      ext_end_here  = '0;
      host_len      = '0;
      held_status   = ST_NO_NAME;
      host_done     = 1'b0;
   endtask

   task automatic stop_walk(input status_type st);
      held_status = st;
      walk_phase  = PH_DONE;
   endtask

   // need a full type + length header left in the block
   task automatic next_extension(input logic [POS_BITS-1:0] at);
      if (pos_add(at, EXT_HEAD_LEN) > ext_block_end)
         stop_walk(ST_NO_NAME);
      else
         walk_phase = PH_ET_HI;
   endtask

   task automatic count_down(output bit drained);
      if (left_in_field <= 1) begin
         left_in_field = '0;
         drained = 1'b1;
      end else begin
         left_in_field = left_in_field - 1'b1;
         drained = 1'b0;
      end
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic eop);
      logic [POS_BITS-1:0] nxt;
      logic [15:0]         word;
      bit                  drained;
      status_type          st;
      rsp_item_type        item;
      nxt  = pos_add(byte_pos, 17'd1);
      word = {held_byte, b};
      case (walk_phase)
         PH_HDR: begin
            if ((byte_pos == 0 && b != REC_HANDSHAKE) ||
                (byte_pos == 1 && b != VER_MAJOR) ||
                (byte_pos == 2 && (b < VER_MINOR_LO || b > VER_MINOR_HI)) ||
                (byte_pos == 5 && b != HS_CLIENT_HELLO))
               stop_walk(ST_NOT_CH);
            else if (byte_pos >= HDR_LAST)
               walk_phase = PH_SID_LEN;
         end
         PH_SID_LEN: begin
            left_in_field = b;
            walk_phase = (b != 0) ? PH_SID_SKIP : PH_CS_HI;
         end
         PH_SID_SKIP: begin
            count_down(drained);
            if (drained) walk_phase = PH_CS_HI;
         end
         PH_CS_HI, PH_EXT_HI, PH_ET_HI, PH_EL_HI, PH_SNI_N1: begin
            held_byte  = b;
            walk_phase = phase_type'(walk_phase + 5'd1);
         end
         PH_CS_LO: begin
            left_in_field = word;
            walk_phase = (word != 0) ? PH_CS_SKIP : PH_CM_LEN;
         end
         PH_CS_SKIP: begin
            count_down(drained);
            if (drained) walk_phase = PH_CM_LEN;
         end
         PH_CM_LEN: begin
            left_in_field = b;
            walk_phase = (b != 0) ? PH_CM_SKIP : PH_EXT_HI;
         end
         PH_CM_SKIP: begin
            count_down(drained);
            if (drained) walk_phase = PH_EXT_HI;
         end
         PH_EXT_LO: begin
            ext_block_end = pos_add(nxt, word);
            next_extension(nxt);
         end
         PH_ET_LO: begin
            ext_kind   = word;
            walk_phase = PH_EL_HI;
         end
         PH_EL_LO: begin
            ext_end_here = pos_add(nxt, word);
            if (ext_end_here > ext_block_end)
               stop_walk(ST_BAD);
            else if (ext_kind == EXT_SERVER_NAME) begin
               if (word < SNI_MIN_LEN) stop_walk(ST_BAD);
               else walk_phase = PH_SNI_L1;
            end else if (word == 0)
               next_extension(nxt);
            else begin
               left_in_field = word;
               walk_phase = PH_EXT_SKIP;
            end
         end
         PH_EXT_SKIP: begin
            count_down(drained);
            if (drained) next_extension(nxt);
         end
         PH_SNI_L1, PH_SNI_L2: walk_phase = phase_type'(walk_phase + 5'd1);
         PH_SNI_TYPE: begin
            if (b != SNI_HOST_NAME) stop_walk(ST_BAD);
            else walk_phase = PH_SNI_N1;
         end
         PH_SNI_N2: begin
            if (pos_add(nxt, word) > ext_end_here)
               stop_walk(ST_BAD);
            else begin
               host_len = word;
               if (word == 0) begin
                  host_done = 1'b1;
                  stop_walk(ST_FOUND);
               end else begin
                  left_in_field = word;
                  walk_phase = PH_NAME;
               end
            end
         end
         PH_NAME: begin
            item.final_res   = 1'b0;
            item.name_byte   = b;
            item.status      = ST_FOUND;
            item.name_length = 16'd0;
            expected_q.push_back(item);
            count_down(drained);
            if (drained) begin
               host_done = 1'b1;
               stop_walk(ST_FOUND);
            end
         end
         default: ;
      endcase
      byte_pos = nxt;

      if (eop) begin
         if (byte_pos < MIN_PACKET || (walk_phase == PH_DONE && held_status == ST_NOT_CH))
            st = ST_NOT_CH;
         else if (walk_phase != PH_DONE || byte_pos < ext_block_end)
            st = ST_BAD;
         else if (held_status == ST_FOUND)
            st = host_done ? ST_FOUND : ST_BAD;
         else
            st = held_status;
         item.final_res   = 1'b1;
         item.name_byte   = 8'd0;
         item.status      = st;
         item.name_length = (st == ST_FOUND) ? host_len : 16'd0;
         expected_q.push_back(item);
         clear_walk();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] wanted);
      if (faults < PRINT_LIMIT)
         $display("%0t ns checker: %s got 0x%0h wanted 0x%0h", $time, what, got, wanted);
      faults++;
   endtask

   // results are compared before the same edge's byte is parsed
   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         clear_walk();
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0)
               report_mismatch("result transaction with nothing pending", rsp_tdata, 0);
            else begin
               want = expected_q.pop_front();
               if (rsp_tlast !== want.final_res)
                  report_mismatch("verdict flag", rsp_tlast, want.final_res);
               if (rsp_tdata[7:0] !== want.name_byte)
                  report_mismatch("name byte", rsp_tdata[7:0], want.name_byte);
               if (rsp_tdata[9:8] !== want.status)
                  report_mismatch("status", rsp_tdata[9:8], want.status);
               if (rsp_tdata[25:10] !== want.name_length)
                  report_mismatch("name length", rsp_tdata[25:10], want.name_length);
               if (rsp_tdata[31:26] !== 6'd0)
                  report_mismatch("tdata padding", rsp_tdata[31:26], 0);
            end
         end
         if (req_tvalid && req_tready)
            parse_byte(req_tdata, req_tlast);
      end
      mismatch_count <= faults;
      expected_count <= expected_q.size();
   end

endmodule

### tb/sv/tb_tls_client_hello_sni_extractor_top.sv
// ----------------------------------------------------------------------------
// tb_tls_client_hello_sni_extractor_top
// Streams ClientHello records, clean and damaged, into the host-name extractor.
// A checker beside the block predicts each result transaction; this module
// builds the packets, drives both handshakes with random gaps and back-pressure
// and prints the verdict.
// ----------------------------------------------------------------------------
module tb_tls_client_hello_sni_extractor_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tlssni_pkg::*;

   localparam int RUN_BYTES   = 750;     // random part, packet bytes
   localparam int HOLD_CYCLES = 120;     // long rsp stall for the pressure packet
   localparam int IDLE_PCT    = 32;
   localparam int DRAIN_WAIT  = 16;

   // one packet recipe; all sizes in bytes
   typedef struct packed {
      int rec_type;       // record header
      int major;
      int minor;
      int hs_type;
      int sid_n;          // session id
      int cs_n;           // cipher suites
      int cm_n;           // compression methods
      int pre_ext;        // plain extensions ahead of the server-name one
      bit sni;
      int name_n;         // host name bytes actually carried
      int name_kind;      // entry type inside the server-name list
      int sni_slack;      // spare bytes after the name inside the extension
      int sni_len_cut;    // shaved off the declared extension length
      int name_len_add;   // added to the declared name length
      int post_ext;
      int ext_total_add;  // skew of the declared extension block length
      int cut;            // >0: packet truncated to this many bytes
      int trail;          // junk after the structure
   } hello_plan;

   typedef enum {
      FLAW_REC, FLAW_MAJOR, FLAW_MINOR, FLAW_HS, FLAW_NAME_KIND,
      FLAW_SNI_SHORT, FLAW_NAME_LONG, FLAW_BLOCK_LONG, FLAW_BLOCK_SHORT, FLAW_CUT
   } flaw_kind;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [31:0] rsp_tdata;
   wire         rsp_tlast;

   int          mismatch_count;
   int          expected_count;

   bit          idling   = 1'b1;  // random gaps on both sides
   bit          hold_off = 1'b0;  // request for one long rsp stall
   logic [7:0]  pkt[$];
   logic [7:0]  ext_blk[$];
   int          sent_bytes = 0;

   tls_client_hello_sni_extractor_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   tlssni_stream_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .expected_count (expected_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop far beyond the slowest clean run.
   initial begin
      #(500_000);
      $display("tb_tls_client_hello_sni_extractor_top: done, errors");
      $finish;
   end

   // Receiver: random tready; on request one long stall counted here, so the
   // block's output queue fills and req_tready has to drop.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_tready <= !(idling && $urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   function automatic logic [7:0] any_byte();
      return $urandom_range(0, 255);
   endfunction

   // Well-formed hello with one short host name.
   function automatic hello_plan base_plan();
      hello_plan p;
      p = '0;
      p.rec_type = REC_HANDSHAKE;
      p.major    = VER_MAJOR;
      p.minor    = 3;
      p.hs_type  = HS_CLIENT_HELLO;
      p.cs_n     = 2;
      p.cm_n     = 1;
      p.pre_ext  = 1;
      p.sni      = 1'b1;
      p.name_n   = 4;
      return p;
   endfunction

   // Extension of some nonzero type with zero to six payload bytes.
   task automatic add_plain_ext();
      logic [15:0] kind;
      int          n;
      kind = $urandom_range(1, 65535);
      n    = $urandom_range(0, 6);
      ext_blk.push_back(kind[15:8]);
      ext_blk.push_back(kind[7:0]);
      ext_blk.push_back(8'd0);
      ext_blk.push_back(n[7:0]);
      repeat (n) ext_blk.push_back(any_byte());
   endtask

   task automatic build_hello(input hello_plan p);
      int sni_len;
      int name_decl;
      int total;
      int i;
      pkt.delete();
      ext_blk.delete();
      // record header (5) + handshake type, length, version, random: 43 bytes
      pkt.push_back(p.rec_type[7:0]);
      pkt.push_back(p.major[7:0]);
      pkt.push_back(p.minor[7:0]);
      pkt.push_back(any_byte());
      pkt.push_back(any_byte());
      pkt.push_back(p.hs_type[7:0]);
      repeat (37) pkt.push_back(any_byte());
      pkt.push_back(p.sid_n[7:0]);
      repeat (p.sid_n) pkt.push_back(any_byte());
      pkt.push_back(p.cs_n[15:8]);
      pkt.push_back(p.cs_n[7:0]);
      repeat (p.cs_n) pkt.push_back(any_byte());
      pkt.push_back(p.cm_n[7:0]);
      repeat (p.cm_n) pkt.push_back(any_byte());

      repeat (p.pre_ext) add_plain_ext();
      if (p.sni) begin
         sni_len = 5 + p.name_n + p.sni_slack - p.sni_len_cut;
         if (sni_len < 0) sni_len = 0;
         name_decl = p.name_n + p.name_len_add;
         ext_blk.push_back(8'h00);
         ext_blk.push_back(8'h00);
         ext_blk.push_back(sni_len[15:8]);
         ext_blk.push_back(sni_len[7:0]);
         // list length is not checked by the block, so leave it loose
         ext_blk.push_back(any_byte());
         ext_blk.push_back(any_byte());
         ext_blk.push_back(p.name_kind[7:0]);
         ext_blk.push_back(name_decl[15:8]);
         ext_blk.push_back(name_decl[7:0]);
         repeat (p.name_n) ext_blk.push_back(any_byte());
         repeat (p.sni_slack) ext_blk.push_back(any_byte());
      end
      repeat (p.post_ext) add_plain_ext();

      total = ext_blk.size() + p.ext_total_add;
      if (total < 0) total = 0;
      if (total > 65535) total = 65535;
      pkt.push_back(total[15:8]);
      pkt.push_back(total[7:0]);
      for (i = 0; i < ext_blk.size(); i++) pkt.push_back(ext_blk[i]);
      repeat (p.trail) pkt.push_back(any_byte());
      if (p.cut > 0)
         while (pkt.size() > p.cut) void'(pkt.pop_back());
   endtask

   // Mostly clean hellos with random sizes; about a third carry one defect.
   task automatic random_plan(output hello_plan p);
      flaw_kind pick;
      p = base_plan();
      p.minor     = $urandom_range(1, 4);
      p.sid_n     = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(0, 6);
      p.cs_n      = 2 * $urandom_range(0, 4);
      p.cm_n      = $urandom_range(0, 2);
      p.pre_ext   = $urandom_range(0, 3);
      p.sni       = ($urandom_range(0, 9) != 0);
      p.name_n    = $urandom_range(0, 12);
      p.sni_slack = $urandom_range(0, 2);
      p.post_ext  = $urandom_range(0, 2);
      p.trail     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      if ($urandom_range(0, 99) < 30) begin
         pick = flaw_kind'($urandom_range(0, 9));
         case (pick)
            FLAW_REC:         p.rec_type      = $urandom_range(0, 255);
            FLAW_MAJOR:       p.major         = $urandom_range(0, 255);
            FLAW_MINOR:       p.minor         = $urandom_range(0, 255);
            FLAW_HS:          p.hs_type       = $urandom_range(0, 255);
            FLAW_NAME_KIND:   p.name_kind     = $urandom_range(1, 255);
            FLAW_SNI_SHORT:   p.sni_len_cut   = $urandom_range(1, 5 + p.name_n);
            FLAW_NAME_LONG:   p.name_len_add  = $urandom_range(1, 4);
            FLAW_BLOCK_LONG:  p.ext_total_add = $urandom_range(1, 8);
            FLAW_BLOCK_SHORT: p.ext_total_add = -$urandom_range(1, 6);
            FLAW_CUT:         p.cut           = $urandom_range(1, 90);
            default: ;
         endcase
      end
   endtask

   // One req transaction per byte, tlast on the final one. Valid may drop
   // for a random gap between bytes but never in the middle of a handshake.
   task automatic send_packet();
      int i;
      for (i = 0; i < pkt.size(); i++) begin
         while (idling && $urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= pkt[i];
         req_tlast  <= (i == pkt.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      sent_bytes += pkt.size();
   endtask

   initial begin : stimulus
      hello_plan p;
      int        pkt_index;
      int        n;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed packets ----
      // shortest clean layout; the final byte is a name byte, so that
      // transaction yields a name byte and the verdict
      p = base_plan();
      p.cs_n = 0; p.cm_n = 0; p.pre_ext = 0; p.name_n = 3;
      build_hello(p); send_packet();
      // lowest and highest accepted minor versions, long session id
      p = base_plan(); p.minor = 1; p.sid_n = 32;
      build_hello(p); send_packet();
      p = base_plan(); p.minor = 4; p.post_ext = 2; p.trail = 3; p.sni_slack = 2;
      build_hello(p); send_packet();
      // header rejects
      p = base_plan(); p.minor = 0;
      build_hello(p); send_packet();
      p = base_plan(); p.minor = 5;
      build_hello(p); send_packet();
      p = base_plan(); p.rec_type = 8'h17;
      build_hello(p); send_packet();
      p = base_plan(); p.major = 2;
      build_hello(p); send_packet();
      p = base_plan(); p.hs_type = 2;
      build_hello(p); send_packet();
      // short packets: one byte, 42 bytes, then exactly the 43-byte minimum
      p = base_plan(); p.cut = 1;
      build_hello(p); send_packet();
      p.cut = MIN_PACKET - 1;
      build_hello(p); send_packet();
      p.cut = MIN_PACKET;
      build_hello(p); send_packet();
      // empty host name
      p = base_plan(); p.name_n = 0;
      build_hello(p); send_packet();
      // extensions without a server-name entry
      p = base_plan(); p.sni = 1'b0; p.pre_ext = 2;
      build_hello(p); send_packet();
      // name entry of the wrong kind
      p = base_plan(); p.name_kind = 1;
      build_hello(p); send_packet();
      // server-name extension one byte under its minimum
      p = base_plan(); p.name_n = 0; p.sni_len_cut = 1;
      build_hello(p); send_packet();
      // name claims more than the extension holds
      p = base_plan(); p.name_len_add = 1;
      build_hello(p); send_packet();
      // extension runs past the declared block end
      p = base_plan(); p.ext_total_add = -3;
      build_hello(p); send_packet();
      // name found, but the packet stops short of the declared block end
      p = base_plan(); p.ext_total_add = 5; p.post_ext = 0;
      build_hello(p); send_packet();
      // packet ends inside the name: bytes already out, verdict bad
      p = base_plan(); p.name_n = 10; p.post_ext = 0;
      build_hello(p);
      p.cut = pkt.size() - 4;
      build_hello(p); send_packet();

      // back-pressure: long name while the receiver stalls
      p = base_plan(); p.name_n = 40;
      build_hello(p);
      hold_off = 1'b1;
      send_packet();

      // ---- random packets ----
      sent_bytes = 0;
      pkt_index  = 0;
      while (sent_bytes < RUN_BYTES) begin
         idling = !(pkt_index >= 3 && pkt_index < 6);  // one gap-free stretch
         if ($urandom_range(0, 9) == 0) begin
            pkt.delete();
            n = $urandom_range(1, 60);
            repeat (n) pkt.push_back(any_byte());
         end else begin
            random_plan(p);
            build_hello(p);
         end
         send_packet();
         pkt_index++;
      end
      idling = 1'b1;

      // ---- drain ----
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_tls_client_hello_sni_extractor_top: done, clean");
      else
         $display("tb_tls_client_hello_sni_extractor_top: done, errors");
      $finish;
   end

endmodule
